// ----- hw/rtl/scanline_run_extractor_defines.svh -----
// Assertion macros shared by the scanline run extractor RTL.
// Every macro expects i_clk and i_rst_n to be visible in the module that uses it.
`ifndef SCANLINE_RUN_EXTRACTOR_DEFINES_SVH
`define SCANLINE_RUN_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define SRE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define SRE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/sre_pkg.sv -----
// Package for the scanline run extractor: field widths, payload structs and queue sizing.
// No dependencies.
package sre_pkg;

    // Longest scanline in pixels; a pixel at column MAX_WIDTH-1 always ends its line.
    localparam int MAX_WIDTH   = 4096;
    localparam int COL_W       = $clog2(MAX_WIDTH);

    // Widths of the payload fields.
    localparam int ROW_W       = 12;
    localparam int START_W     = 12;
    localparam int END_W       = 13;
    localparam int TOTAL_W     = 32;

    // Result queue sizing: each pixel can give at most two results.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    // One pixel request.
    typedef struct packed {
        logic             pixel;
        logic [ROW_W-1:0] row;
        logic             line_end;
    } t_pixel_in;

    // One result request.
    typedef struct packed {
        logic               run_valid;
        logic [ROW_W-1:0]   run_row;
        logic [START_W-1:0] run_start;
        logic [END_W-1:0]   run_end;
        logic [END_W-1:0]   run_length;
        logic               line_done;
        logic [TOTAL_W-1:0] black_total;
    } t_run_out;

    // Push strobes from the run logic into the result queue.
    typedef struct packed {
        logic first;
        logic second;
    } t_push;

endpackage

// ----- hw/rtl/sre_outq.sv -----
// Four-entry result queue of the scanline run extractor; takes up to two results a cycle.
// Depends on sre_pkg and scanline_run_extractor_defines.svh.
`include "scanline_run_extractor_defines.svh"

module sre_outq import sre_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_push    i_push,
    input  t_run_out i_res0,
    input  t_run_out i_res1,
    output logic     o_room,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_run_out o_out_data
);

    t_run_out            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr;
    logic [QPTR_W-1:0]   r_rptr;
    logic [COUNT_W-1:0]  r_count;
    logic [QPTR_W-1:0]   n_wptr;
    logic [COUNT_W-1:0]  n_count;
    logic [1:0]          push_num;
    logic                pop;

    // Handshake on the output side.
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_mem[r_rptr];
    assign pop         = o_out_valid && !i_out_stall;

    // Room for a pair of results keeps the input side free of partial pushes.
    assign o_room = (r_count <= COUNT_W'(QUEUE_DEPTH - 2));

    // Pointer and fill arithmetic.
    always_comb begin
        push_num = {1'b0, i_push.first} + {1'b0, i_push.second};
        n_wptr   = r_wptr + QPTR_W'(push_num);
        n_count  = r_count + COUNT_W'(push_num) - COUNT_W'(pop);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_count <= n_count;
            if (pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
        end
    end

    // Entry storage; the second result goes behind the first.
    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_mem[r_wptr] <= i_res0;
        end
        if (i_push.second) begin
            r_mem[r_wptr + QPTR_W'(1)] <= i_res1;
        end
    end

    `SRE_ASSERT_IMP(a_push_with_room, i_push.first || i_push.second, r_count <= COUNT_W'(QUEUE_DEPTH - 2), "result pushed without room for a pair")
    `SRE_ASSERT_IMP(a_second_after_first, i_push.second, i_push.first, "second result pushed without a first")
    `SRE_ASSERT_NXT(a_single_push_count, i_push.first && !i_push.second && !pop, r_count == $past(r_count) + COUNT_W'(1), "queue fill lost a single push")

endmodule

// ----- hw/rtl/sre_core.sv -----
// Pixel register and per-pixel run decision of the scanline run extractor.
// Depends on sre_pkg; feeds up to two results a cycle into the result queue.
module sre_core import sre_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_pixel_in i_in_data,
    input  logic      i_room,
    output t_push     o_push,
    output t_run_out  o_res0,
    output t_run_out  o_res1
);

    // Pixel register.
    logic               r_in_valid;
    t_pixel_in          r_in;

    // Per-line state and the running total.
    logic [COL_W-1:0]   r_col;
    logic               r_held;
    logic               r_in_black;
    logic               r_skip;
    logic               r_run_open;
    logic [ROW_W-1:0]   r_open_row;
    logic [COL_W-1:0]   r_open_start;
    logic [TOTAL_W-1:0] r_total;

    logic [COL_W-1:0]   n_col;
    logic               n_held;
    logic               n_in_black;
    logic               n_skip;
    logic               n_run_open;
    logic [ROW_W-1:0]   n_open_row;
    logic [COL_W-1:0]   n_open_start;
    logic [TOTAL_W-1:0] n_total;

    logic               proc;
    logic               last;
    logic [COL_W-1:0]   w;
    logic [END_W-1:0]   wend;
    logic               judge_emit;
    logic               end_emit;
    t_run_out           judge_res;
    t_run_out           end_res;
    t_run_out           marker;

    // The pixel register advances whenever the queue can take a pair of results.
    assign proc       = r_in_valid && i_room;
    assign o_in_stall = r_in_valid && !i_room;
    assign w          = r_col - COL_W'(1);

    // Judge the held column with the new pixel as lookahead, then handle the line end.
    always_comb begin
        n_col        = r_col;
        n_held       = r_held;
        n_in_black   = r_in_black;
        n_skip       = r_skip;
        n_run_open   = r_run_open;
        n_open_row   = r_open_row;
        n_open_start = r_open_start;
        n_total      = r_total;
        judge_emit   = 1'b0;
        end_emit     = 1'b0;
        last         = r_in.line_end || ({1'b0, r_col} >= (COL_W + 1)'(MAX_WIDTH - 1));
        wend         = '0;
        judge_res    = '0;
        end_res      = '0;
        marker       = '0;

        if (proc) begin
            // Columns from one onwards are judged once their right neighbour is here.
            if (r_col >= COL_W'(2)) begin
                if (r_skip) begin
                    n_skip = 1'b0;
                end else if (r_held) begin
                    if (!r_in_black && !r_in.pixel) begin
                        // Lone black pixel: ignored.
                        n_skip = 1'b1;
                    end else begin
                        n_total    = r_total + TOTAL_W'(1);
                        n_in_black = 1'b1;
                        if (!r_run_open) begin
                            n_run_open   = 1'b1;
                            n_open_row   = r_in.row;
                            n_open_start = w;
                        end
                    end
                end else if (r_in_black) begin
                    if (r_in.pixel) begin
                        // One-pixel white gap: bridged.
                        n_skip = 1'b1;
                    end else begin
                        n_in_black = 1'b0;
                        // A one-pixel run stays open and its start carries over.
                        if (r_open_start != (w - COL_W'(1)) && r_run_open) begin
                            judge_emit = 1'b1;
                            n_run_open = 1'b0;
                        end
                    end
                end
            end

            judge_res.run_valid   = 1'b1;
            judge_res.run_row     = r_open_row;
            judge_res.run_start   = START_W'(r_open_start);
            judge_res.run_end     = END_W'(w) + END_W'(1);
            judge_res.run_length  = judge_res.run_end - END_W'(r_open_start);
            judge_res.black_total = n_total;

            // Closing column at line end: one further on if the last judge set a skip.
            if (n_skip) begin
                wend = END_W'(r_col) + END_W'(1);
            end else if (r_col == '0) begin
                wend = END_W'(1);
            end else begin
                wend = END_W'(r_col);
            end
            end_emit = last && n_in_black && n_run_open
                       && (END_W'(n_open_start) != (wend - END_W'(1)));

            end_res.run_valid   = 1'b1;
            end_res.run_row     = n_open_row;
            end_res.run_start   = START_W'(n_open_start);
            end_res.run_end     = wend + END_W'(1);
            end_res.run_length  = end_res.run_end - END_W'(n_open_start);
            end_res.black_total = n_total;

            marker.line_done   = 1'b1;
            marker.black_total = n_total;

            // Next column, or a fresh line after the marker.
            if (last) begin
                n_col        = '0;
                n_held       = 1'b0;
                n_in_black   = 1'b0;
                n_skip       = 1'b0;
                n_run_open   = 1'b0;
                n_open_row   = '0;
                n_open_start = '0;
            end else begin
                n_held = r_in.pixel;
                n_col  = r_col + COL_W'(1);
            end
        end
    end

    // Order the results of this pixel: a closed run first, the line marker behind it.
    always_comb begin
        o_push.first  = proc && (judge_emit || end_emit || last);
        o_push.second = proc && (judge_emit || end_emit) && last;
        if (judge_emit) begin
            o_res0 = judge_res;
        end else if (end_emit) begin
            o_res0 = end_res;
        end else begin
            o_res0 = marker;
        end
        o_res1 = marker;
    end

    // Pixel register handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Run state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_held       <= 1'b0;
            r_in_black   <= 1'b0;
            r_skip       <= 1'b0;
            r_run_open   <= 1'b0;
            r_open_row   <= '0;
            r_open_start <= '0;
            r_total      <= '0;
        end else begin
            r_col        <= n_col;
            r_held       <= n_held;
            r_in_black   <= n_in_black;
            r_skip       <= n_skip;
            r_run_open   <= n_run_open;
            r_open_row   <= n_open_row;
            r_open_start <= n_open_start;
            r_total      <= n_total;
        end
    end

endmodule

// ----- hw/rtl/scanline_run_extractor.sv -----
// Scanline run extractor: takes one binary pixel request per cycle and gives black runs
// (row, start, end, length) and a marker after every scanline, with a wrapping count of
// black pixels. A pixel is registered, judged from the pixel register, and its results land
// in a four-entry queue. Pixels go in at one per cycle while the queue has room for a pair;
// the output side delivers one request per cycle when not stalled, so the line end, which
// can give two results, may hold the input when the queue is nearly full. Depends on
// sre_pkg, sre_core and sre_outq.
module scanline_run_extractor import sre_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_pixel_in i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_run_out  o_out_data
);

    t_push    push;
    t_run_out res0;
    t_run_out res1;
    logic     room;

    // Run decision.
    sre_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_room     (room),
        .o_push     (push),
        .o_res0     (res0),
        .o_res1     (res1)
    );

    // Result queue.
    sre_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_res0      (res0),
        .i_res1      (res1),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- sim/run_checker.sv -----
// Checker for the scanline run extractor: watches both request channels, predicts the runs
// and line markers of every accepted pixel and compares each result request field by field.
// Depends on sre_pkg for the payload structs and MAX_WIDTH.
module run_checker import sre_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_pixel_in i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_run_out  i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    // Scanline state of the predictor.
    int unsigned        col_idx;
    bit                 prev_pixel;
    bit                 inside_black;
    bit                 skip_col;
    bit                 start_held;
    logic [ROW_W-1:0]   start_row;
    logic [START_W-1:0] start_col;
    logic [TOTAL_W-1:0] black_count;

    t_run_out expected_runs[$];
    t_run_out want;
    int       mismatch_count;

    initial begin
        mismatch_count = 0;
    end

    function automatic void clear_line_state();
        col_idx      = 0;
        prev_pixel   = 1'b0;
        inside_black = 1'b0;
        skip_col     = 1'b0;
        start_held   = 1'b0;
        start_row    = '0;
        start_col    = '0;
    endfunction

    function automatic void push_result(bit is_run, logic [ROW_W-1:0] row_num,
                                        logic [START_W-1:0] first_col, int unsigned end_col);
        t_run_out r;
        r.run_valid   = is_run;
        r.run_row     = row_num;
        r.run_start   = first_col;
        r.run_end     = END_W'(end_col);
        r.run_length  = END_W'(end_col - 32'(first_col));
        r.line_done   = !is_run;
        r.black_total = black_count;
        expected_runs.push_back(r);
    endfunction

    // Judge one column with the next pixel as lookahead; closes a run where one ends.
    function automatic void judge_column(int unsigned col, bit cur, bit nxt,
                                         logic [ROW_W-1:0] row_num);
        if (skip_col) begin
            skip_col = 1'b0;
        end else if (cur) begin
            // A lone black pixel is dropped and the column after it is skipped.
            if (!inside_black && !nxt) begin
                skip_col = 1'b1;
            end else begin
                black_count  = black_count + 1;
                inside_black = 1'b1;
                if (!start_held) begin
                    start_held = 1'b1;
                    start_row  = row_num;
                    start_col  = START_W'(col);
                end
            end
        end else if (inside_black) begin
            // A single white pixel inside a run is bridged.
            if (nxt) begin
                skip_col = 1'b1;
            end else begin
                inside_black = 1'b0;
                if (start_held && 32'(start_col) != col - 1) begin
                    push_result(1'b1, start_row, start_col, col + 1);
                    start_held = 1'b0;
                end
            end
        end
    endfunction

    // Works out the results that one accepted pixel request causes.
    function automatic void predict_runs(t_pixel_in px);
        int unsigned c;
        int unsigned exit_col;
        bit          last;
        c    = col_idx;
        last = px.line_end || (c >= MAX_WIDTH - 1);
        if (c >= 2)
            judge_column(c - 1, prev_pixel, px.pixel, px.row);
        if (last) begin
            // Close a run still open at the line end, then give the line marker.
            if (skip_col)
                exit_col = c + 1;
            else
                exit_col = (c < 1) ? 1 : c;
            if (inside_black && start_held && 32'(start_col) != exit_col - 1)
                push_result(1'b1, start_row, start_col, exit_col + 1);
            push_result(1'b0, '0, '0, 0);
            clear_line_state();
        end else begin
            prev_pixel = px.pixel;
            col_idx    = c + 1;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
            mismatch_count++;
        end
    endfunction

    // Predict on accepted pixels and compare every accepted result request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_line_state();
            black_count = '0;
            expected_runs.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                predict_runs(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (expected_runs.size() == 0) begin
                    $error("Result request with no expected result waiting");
                    mismatch_count++;
                end else begin
                    want = expected_runs.pop_front();
                    check_field("run_valid", 32'(want.run_valid),
                                32'(i_out_data.run_valid));
                    check_field("run_row", 32'(want.run_row), 32'(i_out_data.run_row));
                    check_field("run_start", 32'(want.run_start),
                                32'(i_out_data.run_start));
                    check_field("run_end", 32'(want.run_end), 32'(i_out_data.run_end));
                    check_field("run_length", 32'(want.run_length),
                                32'(i_out_data.run_length));
                    check_field("line_done", 32'(want.line_done),
                                32'(i_out_data.line_done));
                    check_field("black_total", want.black_total, i_out_data.black_total);
                end
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= expected_runs.size();
    end

endmodule

// ----- sim/tb_top.sv -----
// Top of the scanline run extractor testbench: clock, reset, pixel stimulus and receiver
// stalls, with the verdict taken from run_checker.
// Depends on sre_pkg, run_checker and the scanline_run_extractor RTL.
module tb_top;
    import sre_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1550;
    localparam int HOLD_CYCLES  = 300;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY} t_rx_mode;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_pixel_in in_data   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_run_out  out_data;
    int        fail_count;
    int        pending;

    int          burst_left  = 0;
    int          cycle_count = 0;
    int          rx_cycles   = 0;
    int          hold_left   = 0;
    int          mode_left   = 0;
    t_rx_mode    rx_mode     = RX_FREE;

    scanline_run_extractor dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    run_checker u_run_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Give up on a hung run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random stall modes, with two long hold-offs at fixed points to fill the block.
    always @(posedge clk) begin
        rx_cycles++;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (rx_cycles == 500 || rx_cycles == 1100) begin
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(10, 120);
            end
            mode_left--;
            case (rx_mode)
                RX_FREE:  out_stall <= 1'b0;
                RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                default:  out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Offer one pixel request, in bursts mostly with idle gaps between them, and wait for it to go in.
    task automatic send_pixel(bit pix, logic [ROW_W-1:0] row_num, bit last);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= '{pixel: pix, row: row_num, line_end: last};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
    endtask

    // One short scanline from a string of '0' and '1', line end on the last pixel.
    task automatic send_pattern(string bits, logic [ROW_W-1:0] row_num);
        for (int i = 0; i < bits.len(); i++)
            send_pixel(bits[i] == "1", row_num, i == bits.len() - 1);
    endtask

    initial begin : stimulus
        int          random_items;
        int unsigned width;
        int unsigned flip_pct;
        bit          pix;
        bit          noisy;
        logic [ROW_W-1:0] row_num;

        random_items  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed lines: one- and two-pixel lines, a plain run, a lone black pixel and
        // a bridged gap, black up to the line end, and a two-pixel run dropped at the end.
        send_pattern("1", '0);
        send_pattern("11", '1);
        send_pattern("0111000", 12'h5A5);
        send_pattern("01001101110", 12'hA5A);
        send_pattern("0111", 12'd7);
        send_pattern("00011", 12'd4094);

        // Random scanlines with runs of random length; some change row within the line.
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       width = $urandom_range(1, 2);
                8, 9:    width = $urandom_range(25, 90);
                default: width = $urandom_range(3, 24);
            endcase
            flip_pct = $urandom_range(10, 70);
            noisy    = ($urandom_range(0, 9) == 0);
            row_num  = $urandom_range(0, 4095);
            pix      = $urandom_range(0, 1);
            for (int col = 0; col < width; col++) begin
                if (noisy)
                    row_num = $urandom_range(0, 4095);
                if ($urandom_range(0, 99) < flip_pct)
                    pix = !pix;
                send_pixel(pix, row_num, col == width - 1);
            end
            random_items += width;
        end

        // Drain: wait for every expected result, then wait on for stray ones.
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
